/* rtl/pncm_pkg.sv */
// ----------------------------------------------------------------------------
// pncm_pkg
// shared widths, codes and controller/datapath interface types for the
// nearest palette colour match block
// ----------------------------------------------------------------------------
package pncm_pkg;

    // default table depth
    localparam int DEF_ENTRIES  = 64;

    // fixed field widths
    localparam int RGB_W        = 24;
    localparam int CHAN_W       = 8;
    localparam int SQ_W         = 2 * CHAN_W;
    localparam int DIST_W       = SQ_W + 2;
    localparam int COUNT_W      = 16;
    localparam int SLOT_FIELD_W = 6;
    localparam int ENTRY_W      = COUNT_W + RGB_W;

    // stream widths
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 48;
    localparam int OUT_USER_W   = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // item kind codes
    typedef enum logic {
        KIND_ADD   = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture the input item, restart the sweep
        logic issue;   // read the next slot into the distance pipeline
        logic commit;  // update the table and load the output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic empty;      // no slot filled
        logic last_addr;  // sweep address is the last filled slot
        logic busy;       // distance pipeline still holds reads
        logic out_free;   // output register can take a result
    } t_stat;

endpackage

/* rtl/palette_nearest_color_match.sv */
// ----------------------------------------------------------------------------
// palette_nearest_color_match
// palette table of distinct rgb colours with section counts; add items insert
// or count a colour, query items return the exact or nearest stored colour
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                         | tuser
//  s_axis   | in  | color_rgb[23:0]                            | kind
//  m_axis   | out | match_rgb, match_slot, slot_sections, pad  | exact_hit, status
//
//  an item is accepted, then one shared squared-distance unit visits each filled
//  slot in turn through a single-port memory read, followed by a two-stage drain
//  and a commit step; on an empty table the sweep and the drain are skipped
//  reset is synchronous and active low; it empties the table via the fill count
//  a result waits in the output register while the next item is accepted; a
//  commit stalls only while that register is still full
// ----------------------------------------------------------------------------
module palette_nearest_color_match
    import pncm_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // color_rgb[23:0]
    input  logic                  s_axis_tuser,   // kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // match_rgb[23:0], match_slot[29:24],
                                                  // slot_sections[45:30], zero[47:46]
    output logic [OUT_USER_W-1:0] m_axis_tuser    // exact_hit[0], status[2:1]
);

    t_cmd  cmd;
    t_stat stat;

    logic [RGB_W-1:0]        match_rgb;
    logic [SLOT_FIELD_W-1:0] match_slot;
    logic                    exact_hit;
    logic [COUNT_W-1:0]      slot_sections;
    logic [1:0]              status;

    // sequencing
    pncm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // table, distance unit and result register
    pncm_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (s_axis_tuser),
        .i_color         (s_axis_tdata[RGB_W-1:0]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_match_rgb     (match_rgb),
        .o_match_slot    (match_slot),
        .o_exact_hit     (exact_hit),
        .o_slot_sections (slot_sections),
        .o_status        (status)
    );

    // result packing
    assign m_axis_tdata = {2'b00, slot_sections, match_slot, match_rgb};
    assign m_axis_tuser = {status, exact_hit};

endmodule

/* rtl/pncm_ctrl.sv */
// ----------------------------------------------------------------------------
// pncm_ctrl
// controller: accepts an item, runs the slot sweep unless the table is empty,
// waits for the distance pipeline to drain, then commits the result
// ----------------------------------------------------------------------------
module pncm_ctrl
    import pncm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SWEEP  = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.empty ? S_COMMIT : S_SWEEP;
                end
            end
            S_SWEEP: begin
                o_cmd.issue = 1'b1;
                if (i_stat.last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/pncm_datapath.sv */
// ----------------------------------------------------------------------------
// pncm_datapath
// palette memory, fill count, sweep address, shared squared-distance unit,
// best-slot tracker and output register
// ----------------------------------------------------------------------------
module pncm_datapath
    import pncm_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic                    i_kind,
    input  logic [RGB_W-1:0]        i_color,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [RGB_W-1:0]        o_match_rgb,
    output logic [SLOT_FIELD_W-1:0] o_match_slot,
    output logic                    o_exact_hit,
    output logic [COUNT_W-1:0]      o_slot_sections,
    output logic [1:0]              o_status
);

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UW = $clog2(ENTRIES + 1);

    // palette memory, {count, colour} per slot
    logic [ENTRY_W-1:0] r_mem [ENTRIES];

    logic               r_kind;
    logic [RGB_W-1:0]   r_color;
    logic [UW-1:0]      r_used;
    logic [SW-1:0]      r_addr;

    // pipeline stage 1: registered memory read
    logic               r_v1;
    logic [SW-1:0]      r_s1;
    logic [ENTRY_W-1:0] r_rd;

    // pipeline stage 2: channel squares
    logic               r_v2;
    logic [SW-1:0]      r_s2;
    logic [ENTRY_W-1:0] r_e2;
    logic [SQ_W-1:0]    r_sq [3];

    // best slot so far
    logic               r_best_vld;
    logic [DIST_W-1:0]  r_best_d;
    logic [SW-1:0]      r_best_slot;
    logic [ENTRY_W-1:0] r_best_e;

    // output register
    logic                    r_out_vld;
    logic [RGB_W-1:0]        r_o_rgb;
    logic [SLOT_FIELD_W-1:0] r_o_slot;
    logic                    r_o_exact;
    logic [COUNT_W-1:0]      r_o_count;
    logic [1:0]              r_o_status;

    logic [SQ_W-1:0]         sq [3];
    logic [DIST_W-1:0]       slot_d;
    logic                    take;
    logic                    hit;
    logic                    full;
    logic [COUNT_W-1:0]      best_cnt;
    logic [COUNT_W-1:0]      inc_cnt;
    logic [SW-1:0]           new_slot;

    // status to the controller
    assign full               = (r_used == UW'(ENTRIES));
    assign o_stat.empty       = (r_used == '0);
    assign o_stat.last_addr   = (UW'(r_addr) == r_used - UW'(1));
    assign o_stat.busy        = r_v1 | r_v2;
    assign o_stat.out_free    = !r_out_vld || i_out_ready;

    // channel squared differences of the slot just read
    always_comb begin
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] d;
        for (int c = 0; c < 3; c++) begin
            a     = r_rd[c*CHAN_W +: CHAN_W];
            b     = r_color[c*CHAN_W +: CHAN_W];
            d     = (a > b) ? (a - b) : (b - a);
            sq[c] = d * d;
        end
    end

    // distance sum and strict compare keeps the lowest slot on ties
    assign slot_d = DIST_W'(r_sq[0]) + DIST_W'(r_sq[1]) + DIST_W'(r_sq[2]);
    assign take   = r_v2 && (!r_best_vld || slot_d < r_best_d);

    // commit-time values
    assign hit      = r_best_vld && (r_best_d == '0);
    assign best_cnt = r_best_e[RGB_W +: COUNT_W];
    assign inc_cnt  = (best_cnt == COUNT_MAX) ? best_cnt : best_cnt + COUNT_W'(1);
    assign new_slot = r_used[SW-1:0];

    // slot number masked to the result field width
    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SW-1:0] s);
        logic [SW+SLOT_FIELD_W-1:0] wide;
        wide = (SW + SLOT_FIELD_W)'(s);
        return wide[SLOT_FIELD_W-1:0];
    endfunction

    // palette memory: sweep read and commit write
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd <= r_mem[r_addr];
        end
        if (i_cmd.commit && r_kind == KIND_ADD) begin
            if (hit) begin
                r_mem[r_best_slot] <= {inc_cnt, r_color};
            end else if (!full) begin
                r_mem[new_slot] <= {COUNT_W'(1), r_color};
            end
        end
    end

    // item capture, sweep address and pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_color <= i_color;
        end
        if (i_cmd.load) begin
            r_addr <= '0;
        end else if (i_cmd.issue) begin
            r_addr <= r_addr + SW'(1);
        end
        r_s1 <= r_addr;
        r_s2 <= r_s1;
        r_e2 <= r_rd;
        for (int c = 0; c < 3; c++) begin
            r_sq[c] <= sq[c];
        end
        if (take) begin
            r_best_d    <= slot_d;
            r_best_slot <= r_s2;
            r_best_e    <= r_e2;
        end
    end

    // control: fill count, pipeline valids, best valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_best_vld <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.load) begin
                r_best_vld <= 1'b0;
            end else if (take) begin
                r_best_vld <= 1'b1;
            end
            if (i_cmd.commit && r_kind == KIND_ADD && !hit && !full) begin
                r_used <= r_used + UW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_rgb    <= '0;
            r_o_slot   <= '0;
            r_o_exact  <= 1'b0;
            r_o_count  <= '0;
            r_o_status <= STATUS_OK;
            if (r_kind == KIND_ADD) begin
                if (hit) begin
                    r_o_rgb   <= r_color;
                    r_o_slot  <= slot_field(r_best_slot);
                    r_o_exact <= 1'b1;
                    r_o_count <= inc_cnt;
                end else if (!full) begin
                    r_o_rgb   <= r_color;
                    r_o_slot  <= slot_field(new_slot);
                    r_o_count <= COUNT_W'(1);
                end else begin
                    r_o_status <= STATUS_FULL;
                end
            end else begin
                if (r_best_vld) begin
                    r_o_rgb   <= r_best_e[RGB_W-1:0];
                    r_o_slot  <= slot_field(r_best_slot);
                    r_o_exact <= hit;
                    r_o_count <= best_cnt;
                end else begin
                    r_o_status <= STATUS_EMPTY;
                end
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_match_rgb     = r_o_rgb;
    assign o_match_slot    = r_o_slot;
    assign o_exact_hit     = r_o_exact;
    assign o_slot_sections = r_o_count;
    assign o_status        = r_o_status;

endmodule

/* rtl/pncm_checker.sv */
// ----------------------------------------------------------------------------
// pncm_checker
// port-level checks on the result stream of the palette match block
// ----------------------------------------------------------------------------
module pncm_checker
    import pncm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    logic [1:0] status;
    assign status = m_axis_tuser[2:1];

    // no undefined status code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (status == STATUS_OK || status == STATUS_EMPTY ||
                           status == STATUS_FULL))
        else $error("undefined status code");

    // error results carry all-zero fields
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && status != STATUS_OK) |->
            (m_axis_tdata == '0 && !m_axis_tuser[0]))
        else $error("error result with non-zero fields");

    // an ok result names a slot holding at least one section
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && status == STATUS_OK) |-> (m_axis_tdata[45:30] != '0))
        else $error("ok result with zero section count");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind palette_nearest_color_match pncm_checker u_pncm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* test/palette_nearest_color_match_test.sv */
// ----------------------------------------------------------------------------
// palette_nearest_color_match_test
// self-checking bench for the palette colour match block: a behavioural copy
// of the palette table predicts every result, directed items cover the empty
// table, repeated adds of one colour, exact hits, nearest matches and distance
// ties, and a long random stream fills the table and keeps adding past full,
// with random idling on both stream sides and a hold-off on the receiver
// side
module palette_nearest_color_match_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pncm_pkg::*;

    localparam int          TABLE_SLOTS    = DEF_ENTRIES;
    localparam int unsigned STALL_LIMIT    = 4000;
    localparam int unsigned DRAIN_CYCLES   = 80;
    localparam int unsigned RANDOM_BLOCKS  = 8;
    localparam int unsigned BLOCK_ITEMS    = 180;
    localparam int unsigned REPEAT_ADDS    = 100;
    localparam int unsigned HOLD_OFF_LEN   = 400;
    localparam int unsigned MAX_REPORTS    = 10;

    // one predicted result item
    typedef struct packed {
        logic [RGB_W-1:0]        rgb;
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    exact;
        logic [COUNT_W-1:0]      sections;
        t_status                 status;
    } t_match_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // color_rgb[23:0]
    logic                  s_axis_tuser;   // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // match_rgb, match_slot, slot_sections, pad
    logic [OUT_USER_W-1:0] m_axis_tuser;   // exact_hit, status

    // behavioural palette table
    logic               pal_valid [TABLE_SLOTS];
    logic [RGB_W-1:0]   pal_colour [TABLE_SLOTS];
    logic [COUNT_W-1:0] pal_count [TABLE_SLOTS];
    int unsigned        pal_used;

    t_match_result expected_matches [$];
    int unsigned   fail_count;
    bit            source_gaps_on;
    bit            sink_gaps_on;
    int unsigned   hold_off_cycles;

    palette_nearest_color_match u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // squared rgb distance
    function automatic int unsigned colour_dist_sq(logic [RGB_W-1:0] a, logic [RGB_W-1:0] b);
        int unsigned total;
        int          d;
        total = 0;
        for (int k = 0; k < 3; k++) begin
            d = int'(a[CHAN_W*k +: CHAN_W]) - int'(b[CHAN_W*k +: CHAN_W]);
            total += d * d;
        end
        return total;
    endfunction

    // apply one item to the palette table and return its result
    function automatic t_match_result predict_match(t_kind kind, logic [RGB_W-1:0] colour);
        t_match_result res;
        int            hit;
        int            best;
        int unsigned   best_d;
        int unsigned   d;
        res  = '{rgb: '0, slot: '0, exact: 1'b0, sections: '0, status: STATUS_OK};
        hit  = -1;
        best = -1;
        best_d = 0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (hit < 0 && pal_valid[i] && pal_colour[i] == colour) hit = i;
        end
        if (hit >= 0) begin
            if (kind == KIND_ADD && pal_count[hit] != COUNT_MAX) pal_count[hit]++;
            res.rgb      = colour;
            res.slot     = SLOT_FIELD_W'(hit);
            res.exact    = 1'b1;
            res.sections = pal_count[hit];
        end else if (kind == KIND_ADD) begin
            if (pal_used < TABLE_SLOTS) begin
                pal_valid[pal_used]  = 1'b1;
                pal_colour[pal_used] = colour;
                pal_count[pal_used]  = COUNT_W'(1);
                res.rgb      = colour;
                res.slot     = SLOT_FIELD_W'(pal_used);
                res.sections = COUNT_W'(1);
                pal_used++;
            end else begin
                res.status = STATUS_FULL;
            end
        end else begin
            // nearest stored colour, first slot wins a tie
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (pal_valid[i]) begin
                    d = colour_dist_sq(pal_colour[i], colour);
                    if (best < 0 || d < best_d) begin
                        best   = i;
                        best_d = d;
                    end
                end
            end
            if (best < 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                res.rgb      = pal_colour[best];
                res.slot     = SLOT_FIELD_W'(best);
                res.sections = pal_count[best];
            end
        end
        return res;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // random colour: stored, near a stored one, channel extremes or anything
    function automatic logic [RGB_W-1:0] pick_colour();
        logic [RGB_W-1:0] c;
        int unsigned      r;
        int               ch;
        r = $urandom_range(99);
        c = RGB_W'($urandom);
        if (pal_used > 0 && r < 60) begin
            c = pal_colour[$urandom_range(pal_used - 1)];
            if (r >= 35) begin
                for (int k = 0; k < 3; k++) begin
                    ch = int'(c[CHAN_W*k +: CHAN_W]) + int'($urandom_range(8)) - 4;
                    if (ch < 0) ch = 0;
                    if (ch > 255) ch = 255;
                    c[CHAN_W*k +: CHAN_W] = CHAN_W'(ch);
                end
            end
        end else if (r < 70) begin
            for (int k = 0; k < 3; k++)
                c[CHAN_W*k +: CHAN_W] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return c;
    endfunction

    // offer one item, wait for acceptance, record its prediction
    task automatic send_item(input t_kind kind, input logic [RGB_W-1:0] colour);
        int unsigned gap;
        gap = source_gaps_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= colour;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_matches.insert(expected_matches.size(), predict_match(kind, colour));
    endtask

    task automatic send_random_item();
        send_item($urandom_range(1) ? KIND_QUERY : KIND_ADD, pick_colour());
    endtask

    // stop offering and wait until every result is back
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge i_clk);
    endtask

    // queries before anything is stored
    task automatic test_empty_table();
        send_item(KIND_QUERY, 24'h000000);
        send_item(KIND_QUERY, 24'hFFFFFF);
        send_item(KIND_QUERY, 24'h5AA55A);
    endtask

    // one colour counted many times back to back, with a single slot filled
    task automatic test_repeated_adds();
        source_gaps_on = 1'b0;
        sink_gaps_on   = 1'b0;
        for (int unsigned n = 0; n < REPEAT_ADDS; n++) send_item(KIND_ADD, 24'h000000);
        send_item(KIND_QUERY, 24'h000000);
        send_item(KIND_QUERY, 24'h010203);
        wait_drained();
        source_gaps_on = 1'b1;
        sink_gaps_on   = 1'b1;
    endtask

    // extremes, exact hits, nearest matches and an equal-distance tie
    task automatic test_directed_colours();
        send_item(KIND_ADD,   24'hFFFFFF);
        send_item(KIND_QUERY, 24'hFFFFFF);
        send_item(KIND_ADD,   24'hFF0000);
        send_item(KIND_ADD,   24'h00FF00);
        send_item(KIND_ADD,   24'h0000FF);
        send_item(KIND_ADD,   24'hFF0000);
        send_item(KIND_QUERY, 24'h800000);
        send_item(KIND_QUERY, 24'h808080);
        send_item(KIND_QUERY, 24'h7F7F7F);
        send_item(KIND_ADD,   24'h101010);
        send_item(KIND_ADD,   24'h101014);
        send_item(KIND_QUERY, 24'h101012);
        send_item(KIND_QUERY, 24'h00FE01);
        send_item(KIND_QUERY, 24'h0101FE);
        send_item(KIND_ADD,   24'h0000FF);
        send_item(KIND_QUERY, 24'hAAAAAA);
    endtask

    // random stream that fills the table and keeps going past full
    task automatic test_random_items();
        for (int unsigned b = 0; b < RANDOM_BLOCKS; b++) begin
            source_gaps_on = (b != 2);
            sink_gaps_on   = (b != 2) && (b != 5);
            for (int unsigned n = 0; n < BLOCK_ITEMS; n++) send_random_item();
        end
        source_gaps_on = 1'b1;
        sink_gaps_on   = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_hold_off();
        source_gaps_on  = 1'b0;
        hold_off_cycles = HOLD_OFF_LEN;
        for (int n = 0; n < 10; n++) send_random_item();
        source_gaps_on = 1'b1;
    endtask

    // sender pauses until the block has returned every result
    task automatic test_drain_pause();
        for (int r = 0; r < 3; r++) begin
            for (int n = 0; n < 5; n++) send_random_item();
            wait_drained();
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_match_result want;
        t_match_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.rgb      = m_axis_tdata[23:0];
            got.slot     = m_axis_tdata[29:24];
            got.sections = m_axis_tdata[45:30];
            got.exact    = m_axis_tuser[0];
            got.status   = t_status'(m_axis_tuser[2:1]);
            if (expected_matches.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result item: rgb %06h slot %0d", got.rgb, got.slot);
            end else begin
                want = expected_matches.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: exp rgb %06h slot %0d hit %0b cnt %0d st %0d, got %s",
                                 want.rgb, want.slot, want.exact, want.sections, want.status,
                                 $sformatf("rgb %06h slot %0d hit %0b cnt %0d st %0d",
                                           got.rgb, got.slot, got.exact, got.sections,
                                           got.status));
                end
            end
        end
    end

    // receiver side ready, with random idling and the requested hold-off
    initial begin : drive_ready
        int unsigned idle_left;
        idle_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_off_cycles--;
            end else if (idle_left > 0) begin
                m_axis_tready <= 1'b0;
                idle_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (sink_gaps_on) idle_left = pick_gap();
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // main sequence
    initial begin
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = KIND_ADD;
        fail_count      = 0;
        source_gaps_on  = 1'b1;
        sink_gaps_on    = 1'b1;
        hold_off_cycles = 0;
        pal_used        = 0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            pal_valid[i]  = 1'b0;
            pal_colour[i] = '0;
            pal_count[i]  = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_repeated_adds();
        test_directed_colours();
        test_random_items();
        test_output_hold_off();
        test_drain_pause();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_matches.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
